>>> hw/rtl/mbr_pkg.sv
// Shared field widths, default sizes and the input word type of the main-data bit reservoir.
package mbr_pkg;

    localparam int BUFFER_BYTES_DEF = 4096;
    localparam int RETAIN_BYTES_DEF = 1024;

    localparam int BYTE_W   = 8;
    localparam int CALL_W   = 13;
    localparam int BACK_W   = 9;
    localparam int FRAME_W  = 13;
    localparam int OFFSET_W = 12;
    localparam int LENGTH_W = 13;

    localparam int QUEUE_DEPTH = 2;

    localparam logic OP_APPEND = 1'b0;
    localparam logic OP_READ   = 1'b1;

    typedef struct packed {
        logic                opcode;
        logic                first_of_call;
        logic [BYTE_W-1:0]   append_byte;
        logic [CALL_W-1:0]   call_bytes;
        logic [BACK_W-1:0]   backpointer;
        logic [FRAME_W-1:0]  frame_bytes;
        logic [OFFSET_W-1:0] read_offset;
        logic [LENGTH_W-1:0] read_length;
    } t_item;

endpackage

>>> hw/rtl/mbr_front.sv
// Front end: accepts words, keeps fill count and ring base, and issues store commands.
module mbr_front #(
    parameter int BUFFER_BYTES = mbr_pkg::BUFFER_BYTES_DEF,
    parameter int RETAIN_BYTES = mbr_pkg::RETAIN_BYTES_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  mbr_pkg::t_item                       i_item,
    output logic                                 o_push,
    input  logic                                 i_queue_ready,
    output logic [$clog2(BUFFER_BYTES)+10:0]     o_cmd
);

    localparam int ADDR_W = $clog2(BUFFER_BYTES);
    localparam int FILL_W = $clog2(BUFFER_BYTES + 1);
    localparam int OV_W   = (FILL_W > mbr_pkg::CALL_W ? FILL_W : mbr_pkg::CALL_W) + 1;
    localparam int HI_W   = (FILL_W > mbr_pkg::OFFSET_W ? FILL_W : mbr_pkg::OFFSET_W) + 1;
    localparam logic [FILL_W-1:0] BufFill  = FILL_W'(BUFFER_BYTES);
    localparam logic [FILL_W-1:0] KeepFill = FILL_W'(RETAIN_BYTES);

    typedef struct packed {
        logic                      wr;
        logic [ADDR_W-1:0]         addr;
        logic [mbr_pkg::BYTE_W-1:0] data;
        logic                      pad;
        logic                      last;
    } t_cmd;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_CALC  = 3'b010,
        S_ISSUE = 3'b100
    } t_front_state;

    t_front_state        r_state, n_state;
    mbr_pkg::t_item      r_item;
    logic [FILL_W-1:0]   r_fill, n_fill;
    logic [ADDR_W-1:0]   r_base, n_base;
    logic [HI_W-1:0]     r_hi, n_hi;

    logic                overflow;
    logic [FILL_W-1:0]   keep;
    logic [FILL_W-1:0]   start;
    logic                in_window;
    logic [HI_W-1:0]     diff;
    t_cmd                cmd;

    // Store index of a logical position; both operands stay below the ring size.
    function automatic logic [ADDR_W-1:0] ring(input logic [ADDR_W-1:0] base,
                                               input logic [FILL_W-1:0] pos);
        logic [FILL_W:0] s;
        s = (FILL_W+1)'(base) + (FILL_W+1)'(pos);
        if (s >= (FILL_W+1)'(BUFFER_BYTES)) begin
            s = s - (FILL_W+1)'(BUFFER_BYTES);
        end
        return s[ADDR_W-1:0];
    endfunction

    assign overflow = r_item.first_of_call &&
                      ((OV_W'(r_fill) + OV_W'(r_item.call_bytes)) > OV_W'(BUFFER_BYTES));
    assign keep     = (r_fill < KeepFill) ? r_fill : KeepFill;
    assign start    = (OV_W'(r_fill) >= OV_W'(r_item.frame_bytes)) ?
                      FILL_W'(OV_W'(r_fill) - OV_W'(r_item.frame_bytes)) : '0;
    assign diff      = r_hi - HI_W'(r_item.backpointer);
    assign in_window = (r_hi >= HI_W'(r_item.backpointer)) && (diff < HI_W'(r_fill));

    always_comb begin
        cmd.wr   = (r_item.opcode == mbr_pkg::OP_APPEND);
        cmd.data = r_item.append_byte;
        cmd.pad  = !in_window;
        cmd.last = ((mbr_pkg::LENGTH_W'(r_item.read_offset) + mbr_pkg::LENGTH_W'(1))
                    == r_item.read_length);
        if (r_item.opcode == mbr_pkg::OP_APPEND) begin
            cmd.addr = ring(r_base, r_fill);
        end else begin
            cmd.addr = ring(r_base, diff[FILL_W-1:0]);
        end
    end

    assign o_cmd   = cmd;
    assign o_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        n_fill  = r_fill;
        n_base  = r_base;
        n_hi    = r_hi;
        o_push  = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_CALC;
                end
            end
            S_CALC: begin
                if (r_item.opcode == mbr_pkg::OP_APPEND) begin
                    if (overflow) begin
                        n_base = ring(r_base, r_fill - keep);
                        n_fill = keep;
                    end
                end else begin
                    n_hi = HI_W'(start) + HI_W'(r_item.read_offset);
                end
                n_state = S_ISSUE;
            end
            S_ISSUE: begin
                if (r_item.opcode == mbr_pkg::OP_APPEND && r_fill >= BufFill) begin
                    // Buffer full: the byte is dropped.
                    n_state = S_IDLE;
                end else if (i_queue_ready) begin
                    o_push  = 1'b1;
                    n_state = S_IDLE;
                    if (r_item.opcode == mbr_pkg::OP_APPEND) begin
                        n_fill = r_fill + FILL_W'(1);
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fill  <= '0;
            r_base  <= '0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            r_base  <= n_base;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hi <= n_hi;
        if (i_valid && o_ready) begin
            r_item <= i_item;
        end
    end

endmodule

>>> hw/rtl/mbr_queue.sv
// Short command queue between the front end and the store back end.
module mbr_queue #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_ready,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data,
    input  logic             i_pop
);

    localparam int PTR_W = $clog2(mbr_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(mbr_pkg::QUEUE_DEPTH + 1);

    logic [WIDTH-1:0] r_slot [mbr_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wp, r_rp;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    assign o_ready = (r_cnt != CNT_W'(mbr_pkg::QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_slot[r_rp];

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !(i_pop && o_valid)) begin
            n_cnt = r_cnt + CNT_W'(1);
        end else if (!i_push && i_pop && o_valid) begin
            n_cnt = r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (i_push) begin
                r_wp <= (r_wp == PTR_W'(mbr_pkg::QUEUE_DEPTH - 1)) ? '0 : r_wp + PTR_W'(1);
            end
            if (i_pop && o_valid) begin
                r_rp <= (r_rp == PTR_W'(mbr_pkg::QUEUE_DEPTH - 1)) ? '0 : r_rp + PTR_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wp] <= i_data;
        end
    end

endmodule

>>> hw/rtl/mbr_back.sv
// Back end: byte store memory, registered read and the result output register.
module mbr_back #(
    parameter int BUFFER_BYTES = mbr_pkg::BUFFER_BYTES_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    input  logic [$clog2(BUFFER_BYTES)+10:0]  i_cmd,
    output logic                              o_pop,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [mbr_pkg::BYTE_W-1:0]        o_byte,
    output logic                              o_pad,
    output logic                              o_last
);

    localparam int ADDR_W = $clog2(BUFFER_BYTES);

    typedef struct packed {
        logic                       wr;
        logic [ADDR_W-1:0]          addr;
        logic [mbr_pkg::BYTE_W-1:0] data;
        logic                       pad;
        logic                       last;
    } t_cmd;

    t_cmd                       cmd;
    logic [mbr_pkg::BYTE_W-1:0] r_mem [BUFFER_BYTES];
    logic [mbr_pkg::BYTE_W-1:0] r_rdata;
    logic                       r_pad, r_last, r_out_valid;

    assign cmd   = i_cmd;
    // A read leaves the queue only when the output register is free or being emptied.
    assign o_pop = i_valid && (cmd.wr || !r_out_valid || i_ready);

    always_ff @(posedge i_clk) begin
        if (o_pop && cmd.wr) begin
            r_mem[cmd.addr] <= cmd.data;
        end
        if (o_pop && !cmd.wr) begin
            r_rdata <= r_mem[cmd.addr];
            r_pad   <= cmd.pad;
            r_last  <= cmd.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_pop && !cmd.wr) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_valid = r_out_valid;
    assign o_byte  = r_pad ? '0 : r_rdata;
    assign o_pad   = r_pad;
    assign o_last  = r_last;

endmodule

>>> hw/rtl/mp3_bit_reservoir_window_top.sv
// Top level of the MP3 main-data bit reservoir with windowed byte reads.
//
// The block keeps MP3 main-data bytes in a ring of BUFFER_BYTES entries and
// serves byte reads from a window placed relative to the current frame.
// Each input word is either an append (opcode 0) or a window read (opcode 1).
// An append gives no result; a read gives exactly one result word carrying
// the byte, a padding flag and an end-of-window mark. The front end takes a
// new word only once the last is issued or dropped: it accepts the word, does
// the overflow trim (keeping the newest RETAIN_BYTES bytes by moving the ring
// base) or the frame start arithmetic, then forms the store address and hands
// the command to a two-entry queue, waiting while it is full. The back end
// makes one access of the single-port byte store per cycle unless a read
// waits for the output register; a read result is shown in the cycle after
// its command leaves the queue, held in that register so the front end
// keeps accepting words while a result waits, until the queue fills. The
// store needs no clearing after reset: only written bytes below the fill show.
module mp3_bit_reservoir_window_top #(
    parameter int BUFFER_BYTES = mbr_pkg::BUFFER_BYTES_DEF,
    parameter int RETAIN_BYTES = mbr_pkg::RETAIN_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // Fields from bit 0: append_byte[7:0], call_bytes[20:8], backpointer[29:21],
    // frame_bytes[42:30], read_offset[54:43], read_length[67:55], zeros[71:68].
    input  logic [71:0] s_axis_tdata,
    // Fields from bit 0: opcode[0], first_of_call[1].
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // Fields from bit 0: read_byte[7:0].
    output logic [7:0]  m_axis_tdata,
    // Fields from bit 0: was_padding[0].
    output logic        m_axis_tuser,
    // last_of_read.
    output logic        m_axis_tlast
);

    localparam int CMD_W = $clog2(BUFFER_BYTES) + 11;

    mbr_pkg::t_item   item;
    logic             push, queue_ready, cmd_valid, pop;
    logic [CMD_W-1:0] front_cmd, back_cmd;

    // Unpack the input word into its fields.
    always_comb begin
        item.opcode        = s_axis_tuser[0];
        item.first_of_call = s_axis_tuser[1];
        item.append_byte   = s_axis_tdata[7:0];
        item.call_bytes    = s_axis_tdata[20:8];
        item.backpointer   = s_axis_tdata[29:21];
        item.frame_bytes   = s_axis_tdata[42:30];
        item.read_offset   = s_axis_tdata[54:43];
        item.read_length   = s_axis_tdata[67:55];
    end

    mbr_front #(
        .BUFFER_BYTES(BUFFER_BYTES),
        .RETAIN_BYTES(RETAIN_BYTES)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (s_axis_tvalid),
        .o_ready      (s_axis_tready),
        .i_item       (item),
        .o_push       (push),
        .i_queue_ready(queue_ready),
        .o_cmd        (front_cmd)
    );

    mbr_queue #(
        .WIDTH(CMD_W)
    ) u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_data (front_cmd),
        .o_ready(queue_ready),
        .o_valid(cmd_valid),
        .o_data (back_cmd),
        .i_pop  (pop)
    );

    mbr_back #(
        .BUFFER_BYTES(BUFFER_BYTES)
    ) u_back (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(cmd_valid),
        .i_cmd  (back_cmd),
        .o_pop  (pop),
        .o_valid(m_axis_tvalid),
        .i_ready(m_axis_tready),
        .o_byte (m_axis_tdata),
        .o_pad  (m_axis_tuser),
        .o_last (m_axis_tlast)
    );

endmodule

>>> bench/mbr_window_checker.sv
// Checker for the main-data bit reservoir: mirrors its state, predicts every window read and compares.
module mbr_window_checker #(
    parameter int BUFFER_BYTES = mbr_pkg::BUFFER_BYTES_DEF,
    parameter int RETAIN_BYTES = mbr_pkg::RETAIN_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    input  logic        i_s_axis_tready,
    // Fields from bit 0: append_byte, call_bytes, backpointer, frame_bytes,
    // read_offset, read_length, zeros.
    input  logic [71:0] i_s_axis_tdata,
    // Fields from bit 0: opcode, first_of_call.
    input  logic [1:0]  i_s_axis_tuser,
    input  logic        i_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // Fields from bit 0: read_byte.
    input  logic [7:0]  i_m_axis_tdata,
    // Fields from bit 0: was_padding.
    input  logic        i_m_axis_tuser,
    input  logic        i_m_axis_tlast,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_read_count,
    output int          o_pad_count,
    output int          o_trim_count,
    output int          o_drop_count
);

    timeunit 1ns;
    timeprecision 1ps;

    localparam int ADDR_W = $clog2(BUFFER_BYTES);

    typedef struct {
        logic [mbr_pkg::BYTE_W-1:0] read_byte;
        logic                       was_padding;
        logic                       last_of_read;
    } t_window_result;

    logic [mbr_pkg::BYTE_W-1:0] mirror_bytes [BUFFER_BYTES];
    int unsigned                mirror_fill;
    int unsigned                mirror_base;
    t_window_result             window_due [$];

    // One appended byte, with the overflow trim on the first byte of a call.
    task automatic take_append(input mbr_pkg::t_item w);
        int unsigned keep;
        if (w.first_of_call && mirror_fill + w.call_bytes > BUFFER_BYTES) begin
            keep = (mirror_fill < RETAIN_BYTES) ? mirror_fill : RETAIN_BYTES;
            mirror_base = (mirror_base + mirror_fill - keep) % BUFFER_BYTES;
            mirror_fill = keep;
            o_trim_count++;
        end
        if (mirror_fill < BUFFER_BYTES) begin
            mirror_bytes[ADDR_W'((mirror_base + mirror_fill) % BUFFER_BYTES)] = w.append_byte;
            mirror_fill++;
        end else begin
            o_drop_count++;
        end
    endtask

    // The window position is frame start minus backpointer plus offset; the
    // frame start floors at zero when the frame is longer than the fill.
    function automatic t_window_result look_up_window(input mbr_pkg::t_item w);
        t_window_result r;
        int unsigned    start;
        int unsigned    hi;
        start = (mirror_fill >= w.frame_bytes) ? mirror_fill - w.frame_bytes : 0;
        hi    = start + w.read_offset;
        if (hi >= w.backpointer && hi - w.backpointer < mirror_fill) begin
            r.read_byte   = mirror_bytes[ADDR_W'((mirror_base + hi - w.backpointer)
                                                 % BUFFER_BYTES)];
            r.was_padding = 1'b0;
        end else begin
            r.read_byte   = '0;
            r.was_padding = 1'b1;
        end
        r.last_of_read = (w.read_offset + 1 == w.read_length);
        return r;
    endfunction

    always @(posedge i_clk) begin : watch
        mbr_pkg::t_item w;
        t_window_result want;
        if (!i_rst_n) begin
            mirror_fill = 0;
            mirror_base = 0;
            window_due.delete();
            o_pending = 0;
        end else begin
            if (i_s_axis_tvalid && i_s_axis_tready) begin
                w.opcode        = i_s_axis_tuser[0];
                w.first_of_call = i_s_axis_tuser[1];
                w.append_byte   = i_s_axis_tdata[7:0];
                w.call_bytes    = i_s_axis_tdata[20:8];
                w.backpointer   = i_s_axis_tdata[29:21];
                w.frame_bytes   = i_s_axis_tdata[42:30];
                w.read_offset   = i_s_axis_tdata[54:43];
                w.read_length   = i_s_axis_tdata[67:55];
                if (w.opcode == mbr_pkg::OP_APPEND) begin
                    take_append(w);
                end else begin
                    want = look_up_window(w);
                    window_due.push_back(want);
                    o_read_count++;
                    if (want.was_padding) begin
                        o_pad_count++;
                    end
                end
            end
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                if (window_due.size() == 0) begin
                    $error("Result word with no read outstanding: byte %0d", i_m_axis_tdata);
                    o_fail_count++;
                end else begin
                    want = window_due.pop_front();
                    if (i_m_axis_tdata !== want.read_byte) begin
                        $error("read_byte: expected %0d, actual %0d",
                               want.read_byte, i_m_axis_tdata);
                        o_fail_count++;
                    end
                    if (i_m_axis_tuser !== want.was_padding) begin
                        $error("was_padding: expected %0d, actual %0d",
                               want.was_padding, i_m_axis_tuser);
                        o_fail_count++;
                    end
                    if (i_m_axis_tlast !== want.last_of_read) begin
                        $error("last_of_read: expected %0d, actual %0d",
                               want.last_of_read, i_m_axis_tlast);
                        o_fail_count++;
                    end
                end
            end
            o_pending = window_due.size();
        end
    end

endmodule

>>> bench/tb_top.sv
// Testbench top for the main-data bit reservoir: clock, reset, stimulus, idling and verdict.
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int BUFFER_BYTES = mbr_pkg::BUFFER_BYTES_DEF;
    localparam int RETAIN_BYTES = mbr_pkg::RETAIN_BYTES_DEF;
    // Cycles with no word moving on either side before the run is abandoned.
    localparam int QUIET_LIMIT  = 500;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    // Fields from bit 0: append_byte, call_bytes, backpointer, frame_bytes,
    // read_offset, read_length, zeros.
    logic [71:0] s_axis_tdata  = '0;
    // Fields from bit 0: opcode, first_of_call.
    logic [1:0]  s_axis_tuser  = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // Fields from bit 0: read_byte.
    logic [7:0]  m_axis_tdata;
    // Fields from bit 0: was_padding.
    logic        m_axis_tuser;
    logic        m_axis_tlast;

    int fail_count;
    int pending;
    int read_count;
    int pad_count;
    int trim_count;
    int drop_count;

    // Set for the closing stretch of the run, where neither side idles.
    logic calm_tail = 1'b0;
    int   words_sent = 0;
    int   quiet_cycles = 0;

    // Receiver idling state: whether the current burst is a stall, and its length left.
    logic sink_stalled = 1'b0;
    int   sink_left = 0;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    mp3_bit_reservoir_window_top #(
        .BUFFER_BYTES(BUFFER_BYTES),
        .RETAIN_BYTES(RETAIN_BYTES)
    ) uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .m_axis_tlast (m_axis_tlast)
    );

    mbr_window_checker #(
        .BUFFER_BYTES(BUFFER_BYTES),
        .RETAIN_BYTES(RETAIN_BYTES)
    ) check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tvalid(s_axis_tvalid),
        .i_s_axis_tready(s_axis_tready),
        .i_s_axis_tdata (s_axis_tdata),
        .i_s_axis_tuser (s_axis_tuser),
        .i_m_axis_tvalid(m_axis_tvalid),
        .i_m_axis_tready(m_axis_tready),
        .i_m_axis_tdata (m_axis_tdata),
        .i_m_axis_tuser (m_axis_tuser),
        .i_m_axis_tlast (m_axis_tlast),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_read_count   (read_count),
        .o_pad_count    (pad_count),
        .o_trim_count   (trim_count),
        .o_drop_count   (drop_count)
    );

    // The receiver alternates between stalls and runs of readiness, now and
    // then a long run, so that back-pressure lands on every phase of the
    // block's accept, calculate and issue sequence.
    always @(negedge i_clk) begin
        if (!i_rst_n || calm_tail) begin
            m_axis_tready <= 1'b1;
        end else begin
            if (sink_left == 0) begin
                if ($urandom_range(0, 2) == 0) begin
                    sink_stalled = 1'b1;
                    sink_left    = $urandom_range(1, 5);
                end else begin
                    sink_stalled = 1'b0;
                    sink_left    = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
                                                               : $urandom_range(1, 12);
                end
            end
            m_axis_tready <= !sink_stalled;
            sink_left--;
        end
    end

    // Watchdog: a run in which no word moves for too long has hung.
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Watchdog: no word moved for %0d cycles, %0d reads outstanding",
                     QUIET_LIMIT, pending);
            $display("tb_top failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Every field random: full range, but frame, call and read lengths only up to 4096.
    function automatic mbr_pkg::t_item any_word();
        mbr_pkg::t_item w;
        w.opcode        = 1'($urandom_range(0, 1));
        w.first_of_call = 1'($urandom_range(0, 1));
        w.append_byte   = mbr_pkg::BYTE_W'($urandom_range(0, 255));
        w.call_bytes    = mbr_pkg::CALL_W'($urandom_range(1, 4096));
        w.backpointer   = mbr_pkg::BACK_W'($urandom_range(0, 511));
        w.frame_bytes   = mbr_pkg::FRAME_W'($urandom_range(0, 4096));
        w.read_offset   = mbr_pkg::OFFSET_W'($urandom_range(0, 4095));
        w.read_length   = mbr_pkg::LENGTH_W'($urandom_range(1, 4096));
        return w;
    endfunction

    // Offers one word from a falling edge and returns at the falling edge
    // after it has been taken. Outside the calm tail the sender sometimes
    // idles first.
    task automatic feed_word(input mbr_pkg::t_item w);
        int gap;
        if (!calm_tail && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 5);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0000, w.read_length, w.read_offset, w.frame_bytes,
                          w.backpointer, w.call_bytes, w.append_byte};
        s_axis_tuser  <= {w.first_of_call, w.opcode};
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
        words_sent++;
    endtask

    // The fields an append ignores carry random values, so that the block
    // is seen to ignore them; likewise for a read.
    task automatic send_append(input int value, input int first, input int call);
        mbr_pkg::t_item w;
        w               = any_word();
        w.opcode        = mbr_pkg::OP_APPEND;
        w.append_byte   = mbr_pkg::BYTE_W'(value);
        w.first_of_call = 1'(first);
        w.call_bytes    = mbr_pkg::CALL_W'(call);
        feed_word(w);
    endtask

    task automatic send_read(input int back, input int frame, input int offset, input int len);
        mbr_pkg::t_item w;
        w             = any_word();
        w.opcode      = mbr_pkg::OP_READ;
        w.backpointer = mbr_pkg::BACK_W'(back);
        w.frame_bytes = mbr_pkg::FRAME_W'(frame);
        w.read_offset = mbr_pkg::OFFSET_W'(offset);
        w.read_length = mbr_pkg::LENGTH_W'(len);
        feed_word(w);
    endtask

    // The sender stands back until every outstanding read has been answered.
    task automatic hold_for_results();
        s_axis_tvalid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
    endtask

    // Mostly well-formed frames (an append call followed by a window over
    // it), with broken calls, stray windows and fully random words mixed in.
    // Once a pick starts with at most calm_last words left, no side idles.
    task automatic mixed_traffic(input int count, input int calm_last);
        int stop;
        int pick;
        int n;
        int len;
        int back;
        int frame;
        int k;
        stop = words_sent + count;
        while (words_sent < stop) begin
            if (stop - words_sent <= calm_last) begin
                calm_tail = 1'b1;
            end
            pick = $urandom_range(0, 9);
            if (pick < 6) begin
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 24);
                for (int i = 0; i < n; i++) begin
                    send_append($urandom_range(0, 255), int'(i == 0), n);
                end
                // Main data usually begins a short way back in earlier frames.
                back = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 511) : $urandom_range(0, 40);
                len  = $urandom_range(1, 16);
                for (int i = 0; i < len; i++) begin
                    send_read(back, n, i, len);
                end
            end else if (pick < 8) begin
                if ($urandom_range(0, 1) == 1) begin
                    // A call whose stated length bears no relation to its bytes,
                    // sometimes without its first-byte mark.
                    n   = $urandom_range(1, 12);
                    len = $urandom_range(1, 4096);
                    for (int i = 0; i < n; i++) begin
                        send_append($urandom_range(0, 255),
                                    int'(i == 0 && $urandom_range(0, 3) != 0), len);
                    end
                end else begin
                    // A window entered part-way, possibly running past its end.
                    n     = $urandom_range(1, 6);
                    k     = $urandom_range(0, 40);
                    len   = $urandom_range(1, 32);
                    back  = $urandom_range(0, 511);
                    frame = $urandom_range(0, 4096);
                    for (int i = 0; i < n; i++) begin
                        send_read(back, frame, k + i, len);
                    end
                end
            end else begin
                repeat ($urandom_range(1, 4)) feed_word(any_word());
            end
        end
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part. A read of the empty buffer is padding, and its
        // window of one word is also its last.
        send_read(0, 0, 0, 1);
        // A call of stated length zero never trims, but its byte still lands.
        send_append('h00, 1, 0);
        send_append('hFF, 0, 1);
        send_append('hA5, 1, 3);
        send_append('h5A, 0, 3);
        send_append('h01, 0, 3);
        // A zero-length window never marks a last word; this one pads as
        // it sits just past the fill.
        send_read(0, 0, 0, 0);
        // The whole of the five stored bytes, the last one marked.
        for (int i = 0; i < 5; i++) begin
            send_read(5, 0, i, 5);
        end
        // A frame longer than the fill: the frame start floors at zero.
        send_read(0, 4096, 0, 4096);
        // Largest offset with the largest backpointer, far past the fill.
        send_read(511, 0, 4095, 4096);
        // A position before the first stored byte.
        send_read(511, 4096, 0, 1);
        // An offset beyond the window length still reads a byte, unmarked.
        send_read(3, 2, 3, 2);
        // A call length of 4096 trips the overflow check, but with fewer
        // bytes than the keep size everything stays.
        send_append('h3C, 1, 4096);
        send_read(6, 0, 0, 1);
        hold_for_results();

        mixed_traffic(260, 0);
        hold_for_results();
        mixed_traffic(270, 60);

        // Let the last reads drain, then allow a short tail in which any
        // stray result word would still be caught.
        hold_for_results();
        repeat (20) @(posedge i_clk);

        $display("Covered %0d words in: %0d window reads (%0d padded), %0d overflow trims,",
                 words_sent, read_count, pad_count, trim_count);
        $display("%0d bytes dropped at full, with both sides idling at random until the tail.",
                 drop_count);
        if (fail_count == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule
